// ===== hw/rtl/pmft_pkg.sv =====
// Shared types and constants for the page-mapped flash translation block.
// Used by page_mapped_flash_translation; no dependencies of its own.
`timescale 1ns / 1ps

package pmft_pkg;

	localparam int IN_W  = 136;	// lba, data_lo, data_hi
	localparam int OUT_W = 144;	// rdata_lo, rdata_hi, phys_page, collected, reclaimed

	localparam logic [7:0] NO_PAGE = 8'hFF;

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_READ  = 2'd1,
		OP_GC    = 2'd2
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_RANGE    = 2'd1,
		ST_FULL     = 2'd2,
		ST_UNMAPPED = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		PG_FREE  = 2'd0,
		PG_VALID = 2'd1,
		PG_DIRTY = 2'd2
	} page_state_t;

	// Byte mask of the bytes a physical page really holds.
	function automatic logic [127:0] page_mask(input int bytes);
		logic [127:0] m;
		m = '0;
		for (int i = 0; i < 16; i++) begin
			if (i < bytes) begin
				m[i*8 +: 8] = 8'hFF;
			end
		end
		return m;
	endfunction

endpackage

// ===== hw/rtl/pmft_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module pmft_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hw/rtl/page_mapped_flash_translation.sv =====
// Top level of the page-mapped flash translation block: sequencer, tables and page store.
// Depends on pmft_pkg and pmft_ram.
`timescale 1ns / 1ps

// Usage
// A request enters on the s_ channel: s_tuser carries the opcode (write page, read page,
// run garbage collection), s_tdata the logical page and the 16 data bytes. Each request
// gives exactly one result on the m_ channel: m_tuser carries the status, m_tdata the
// read data, the physical page, the collected flag and the reclaimed count.
// Requests are handled one at a time by a sequencer around four RAMs (map table, page
// state, free-list links, page store), each with a registered read.
// A request is taken again in the cycle after its result is loaded; the block takes no
// new request before the last one has its result loaded.
// Garbage collection scans every physical page through the page-state RAM, one page per
// cycle: a collection request gives its result when the scan ends, and a write that
// triggers one goes back to its check for a free page.
// Reset clears the map and page-state valid bits at once; entries not yet written read
// as their reset value, so requests are taken from the first cycle after reset.
// The result sits in an output register: a new request is accepted while it waits, and
// only the loading of the next result stalls until m_tready takes the pending one.
module page_mapped_flash_translation #(
	parameter int USER_PAGE_COUNT = 64,
	parameter int PHYS_PAGE_COUNT = 128,
	parameter int PAGE_BYTES      = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [pmft_pkg::IN_W-1:0] s_tdata,   // lba[7:0], data_lo[71:8], data_hi[135:72]
	input  logic [1:0]                s_tuser,   // opcode[1:0]
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [pmft_pkg::OUT_W-1:0] m_tdata,  // rdata_lo[63:0], rdata_hi[127:64],
	                                             // phys_page[134:128], collected[135],
	                                             // reclaimed[143:136]
	output logic [1:0]                m_tuser    // status[1:0]
);

	import pmft_pkg::*;

	localparam int UAW = (USER_PAGE_COUNT > 1) ? $clog2(USER_PAGE_COUNT) : 1;
	localparam int PW  = $clog2(PHYS_PAGE_COUNT);
	localparam int SW  = $clog2(PHYS_PAGE_COUNT + 1);
	localparam logic [7:0]   USER_N    = 8'(USER_PAGE_COUNT);
	localparam logic [7:0]   PHYS_N    = 8'(PHYS_PAGE_COUNT);
	localparam logic [SW-1:0] SCAN_END = SW'(PHYS_PAGE_COUNT);
	localparam logic [127:0] PAGE_MASK = page_mask(PAGE_BYTES);

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHK,
		S_WMAP,
		S_WVAL,
		S_RMAP,
		S_RDAT,
		S_GC,
		S_OUT
	} state_t;

	state_t          state_q;
	logic [1:0]      op_q;
	logic [7:0]      lba_q;
	logic [127:0]    wdata_q;
	logic [7:0]      head_q;
	logic [PW-1:0]   np_q;
	logic            col_q;
	logic [7:0]      rec_q;
	logic [SW-1:0]   scan_q;
	logic            gc_v_s1;
	logic [PW-1:0]   gc_addr_s1;
	status_t         res_status_q;
	logic [127:0]    res_data_q;
	logic [7:0]      res_pp_q;

	logic [USER_PAGE_COUNT-1:0] map_vld_q;
	logic [PHYS_PAGE_COUNT-1:0] st_vld_q;

	logic            m_tvalid_q;
	status_t         out_status_q;
	logic [127:0]    out_data_q;
	logic [6:0]      out_pp_q;
	logic            out_col_q;
	logic [7:0]      out_rec_q;

	// RAM ports
	logic            map_we, map_re;
	logic [UAW-1:0]  lba_idx;
	logic [PW-1:0]   map_rdata;
	logic            st_we, st_re;
	logic [PW-1:0]   st_waddr, st_raddr;
	logic [1:0]      st_wdata, st_rdata;
	logic            nx_we, nx_re;
	logic [PW-1:0]   nx_raddr;
	logic [7:0]      nx_rdata;
	logic            pg_we, pg_re;
	logic [PW-1:0]   pg_waddr;
	logic [127:0]    pg_wdata, pg_rdata;

	logic            map_hit;
	page_state_t     st_val;
	logic [8:0]      nx_inc;
	logic [7:0]      nx_val;
	logic            gc_dirty;
	logic            out_free;
	logic            opcode_ok;

	assign lba_idx  = lba_q[UAW-1:0];
	assign map_hit  = map_vld_q[lba_idx];
	assign st_val   = st_vld_q[gc_addr_s1] ? page_state_t'(st_rdata) : PG_FREE;
	assign nx_inc   = 9'(np_q) + 9'd1;
	// a free page that was in use before came back through a collection, which wrote its link
	assign nx_val   = st_vld_q[np_q] ? nx_rdata :
	                  (nx_inc < 9'(PHYS_PAGE_COUNT)) ? nx_inc[7:0] : NO_PAGE;
	assign gc_dirty = (state_q == S_GC) && gc_v_s1 && (st_val == PG_DIRTY);
	assign out_free = !m_tvalid_q || m_tready;
	assign opcode_ok = (op_q == OP_WRITE) && (lba_q < USER_N) && (head_q < PHYS_N);

	always_comb begin
		map_we   = 1'b0;
		map_re   = 1'b0;
		st_we    = 1'b0;
		st_re    = 1'b0;
		st_waddr = gc_addr_s1;
		st_wdata = PG_FREE;
		st_raddr = scan_q[PW-1:0];
		nx_we    = 1'b0;
		nx_re    = 1'b0;
		nx_raddr = head_q[PW-1:0];
		pg_we    = 1'b0;
		pg_re    = 1'b0;
		pg_waddr = gc_addr_s1;
		pg_wdata = PAGE_MASK;
		case (state_q)
			S_CHK: begin
				map_re = (lba_q < USER_N);
				nx_re  = opcode_ok;
			end
			S_WMAP: begin
				// mark the previous copy of this page dirty
				st_we    = map_hit;
				st_waddr = map_rdata;
				st_wdata = PG_DIRTY;
				map_we   = 1'b1;
				pg_we    = 1'b1;
				pg_waddr = np_q;
				pg_wdata = wdata_q & PAGE_MASK;
			end
			S_WVAL: begin
				st_we    = 1'b1;
				st_waddr = np_q;
				st_wdata = PG_VALID;
			end
			S_RMAP: begin
				pg_re = map_hit;
			end
			S_GC: begin
				st_re = (scan_q < SCAN_END);
				st_we = gc_dirty;
				nx_we = gc_dirty;
				pg_we = gc_dirty;
			end
			default: begin
			end
		endcase
	end

	pmft_ram #(.WIDTH(PW), .DEPTH(USER_PAGE_COUNT)) u_map_ram (
		.clk   (clk),
		.we    (map_we),
		.waddr (lba_idx),
		.wdata (np_q),
		.re    (map_re),
		.raddr (lba_idx),
		.rdata (map_rdata)
	);

	pmft_ram #(.WIDTH(2), .DEPTH(PHYS_PAGE_COUNT)) u_state_ram (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (st_wdata),
		.re    (st_re),
		.raddr (st_raddr),
		.rdata (st_rdata)
	);

	pmft_ram #(.WIDTH(8), .DEPTH(PHYS_PAGE_COUNT)) u_link_ram (
		.clk   (clk),
		.we    (nx_we),
		.waddr (gc_addr_s1),
		.wdata (head_q),
		.re    (nx_re),
		.raddr (nx_raddr),
		.rdata (nx_rdata)
	);

	pmft_ram #(.WIDTH(128), .DEPTH(PHYS_PAGE_COUNT)) u_page_ram (
		.clk   (clk),
		.we    (pg_we),
		.waddr (pg_waddr),
		.wdata (pg_wdata),
		.re    (pg_re),
		.raddr (map_rdata),
		.rdata (pg_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			op_q         <= '0;
			lba_q        <= '0;
			wdata_q      <= '0;
			head_q       <= '0;
			np_q         <= '0;
			col_q        <= 1'b0;
			rec_q        <= '0;
			scan_q       <= '0;
			gc_v_s1      <= 1'b0;
			gc_addr_s1   <= '0;
			res_status_q <= ST_OK;
			res_data_q   <= '0;
			res_pp_q     <= '0;
			map_vld_q    <= '0;
			st_vld_q     <= '0;
			m_tvalid_q   <= 1'b0;
			out_status_q <= ST_OK;
			out_data_q   <= '0;
			out_pp_q     <= '0;
			out_col_q    <= 1'b0;
			out_rec_q    <= '0;
		end else begin
			if (m_tvalid_q && m_tready && state_q != S_OUT) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						op_q         <= s_tuser;
						lba_q        <= s_tdata[7:0];
						wdata_q      <= s_tdata[135:8];
						col_q        <= 1'b0;
						rec_q        <= '0;
						res_status_q <= ST_OK;
						res_data_q   <= '0;
						res_pp_q     <= '0;
						state_q      <= S_CHK;
					end
				end
				S_CHK: begin
					case (op_q)
						OP_WRITE: begin
							if (lba_q >= USER_N) begin
								res_status_q <= ST_RANGE;
								state_q      <= S_OUT;
							end else if (head_q < PHYS_N) begin
								np_q    <= head_q[PW-1:0];
								state_q <= S_WMAP;
							end else if (col_q) begin
								res_status_q <= ST_FULL;
								state_q      <= S_OUT;
							end else begin
								col_q   <= 1'b1;
								scan_q  <= '0;
								gc_v_s1 <= 1'b0;
								state_q <= S_GC;
							end
						end
						OP_READ: begin
							if (lba_q >= USER_N) begin
								res_status_q <= ST_RANGE;
								state_q      <= S_OUT;
							end else begin
								state_q <= S_RMAP;
							end
						end
						OP_GC: begin
							col_q   <= 1'b1;
							scan_q  <= '0;
							gc_v_s1 <= 1'b0;
							state_q <= S_GC;
						end
						default: begin
							state_q <= S_OUT;
						end
					endcase
				end
				S_WMAP: begin
					// pop the free list and record the new mapping
					head_q             <= nx_val;
					map_vld_q[lba_idx] <= 1'b1;
					res_pp_q           <= 8'(np_q);
					state_q            <= S_WVAL;
				end
				S_WVAL: begin
					st_vld_q[np_q] <= 1'b1;
					state_q        <= S_OUT;
				end
				S_RMAP: begin
					if (!map_hit) begin
						res_status_q <= ST_UNMAPPED;
						state_q      <= S_OUT;
					end else begin
						res_pp_q <= 8'(map_rdata);
						state_q  <= S_RDAT;
					end
				end
				S_RDAT: begin
					res_data_q <= pg_rdata;
					state_q    <= S_OUT;
				end
				S_GC: begin
					// read page scan_q while page gc_addr_s1 is updated
					gc_v_s1    <= (scan_q < SCAN_END);
					gc_addr_s1 <= scan_q[PW-1:0];
					if (scan_q < SCAN_END) begin
						scan_q <= scan_q + SW'(1);
					end
					if (gc_dirty) begin
						st_vld_q[gc_addr_s1] <= 1'b1;
						head_q               <= 8'(gc_addr_s1);
						rec_q                <= rec_q + 8'd1;
					end
					if (scan_q == SCAN_END && !gc_v_s1) begin
						state_q <= (op_q == OP_WRITE) ? S_CHK : S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						m_tvalid_q   <= 1'b1;
						out_status_q <= res_status_q;
						out_data_q   <= res_data_q;
						out_pp_q     <= res_pp_q[6:0];
						out_col_q    <= col_q;
						out_rec_q    <= rec_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {out_rec_q, out_col_q, out_pp_q, out_data_q};

	a_head_legal: assert property (@(posedge clk) disable iff (!arst_n)
		(head_q < PHYS_N) || (head_q == NO_PAGE))
		else $error("free list head points outside the physical pages");

	a_full_after_gc: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && out_status_q == ST_FULL) |-> out_col_q)
		else $error("disk full reported without a collection");

	a_rec_needs_gc: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && out_rec_q != 8'd0) |-> out_col_q)
		else $error("pages reclaimed without a collection");

	a_scan_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_GC && st_we && st_re) |-> (st_waddr != st_raddr))
		else $error("collection scan reads the page it writes");

	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && !out_free) |=> (state_q == S_OUT))
		else $error("result dropped while the output is stalled");

endmodule
